>>> rtl/ubbb_pkg.sv
// ----------------------------------------------------------------------------
// ubbb_pkg
// Shared types and constants of the upper-bound Bellman backup core.
// ----------------------------------------------------------------------------
package ubbb_pkg;

    localparam int PROB_W  = 17;
    localparam int VAL_W   = 32;
    localparam int DISC_W  = 17;
    localparam int IDX_W   = 8;
    localparam int SUM_W   = 48;
    localparam int PROD_W  = 50;
    localparam int RSUM_W  = 33;
    localparam int DPROD_W = 51;

    localparam logic [DISC_W-1:0] DISCOUNT_RST = 17'd62259;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_RND,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic accumulate;
        logic round_mul;
        logic finish;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last_out;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/ubbb_ctrl.sv
// ----------------------------------------------------------------------------
// ubbb_ctrl
// Sequencer of the backup core: accept, accumulate, round, finish and emit steps.
// ----------------------------------------------------------------------------
module ubbb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ubbb_pkg::t_dp_sts i_sts,
    output ubbb_pkg::t_dp_cmd o_cmd
);

    ubbb_pkg::t_state r_state;
    ubbb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ubbb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ubbb_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ubbb_pkg::S_ACC;
            end
            ubbb_pkg::S_ACC: begin
                n_state = i_sts.last_out ? ubbb_pkg::S_RND : ubbb_pkg::S_IDLE;
            end
            ubbb_pkg::S_RND: begin
                n_state = ubbb_pkg::S_FIN;
            end
            ubbb_pkg::S_FIN: begin
                n_state = ubbb_pkg::S_OUT;
            end
            ubbb_pkg::S_OUT: begin
                if (i_sts.out_free) n_state = ubbb_pkg::S_IDLE;
            end
            default: begin
                n_state = ubbb_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ubbb_pkg::S_IDLE: begin
                o_in_ready    = i_rst_n;
                o_cmd.capture = i_in_valid && i_rst_n;
            end
            ubbb_pkg::S_ACC: begin
                o_cmd.accumulate = 1'b1;
            end
            ubbb_pkg::S_RND: begin
                o_cmd.round_mul = 1'b1;
            end
            ubbb_pkg::S_FIN: begin
                o_cmd.finish = 1'b1;
            end
            ubbb_pkg::S_OUT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/ubbb_datapath.sv
// ----------------------------------------------------------------------------
// ubbb_datapath
// Product, saturating sum, discount multiply, maximum tracking and result
// register of the backup core.
// ----------------------------------------------------------------------------
module ubbb_datapath #(
    parameter int MAX_ACTIONS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ubbb_pkg::t_dp_cmd                   i_cmd,
    output ubbb_pkg::t_dp_sts                   o_sts,
    input  logic                                i_cfg_we,
    input  logic [ubbb_pkg::DISC_W-1:0]         i_cfg_data,
    input  logic [ubbb_pkg::PROB_W-1:0]         i_prob,
    input  logic signed [ubbb_pkg::VAL_W-1:0]   i_next_bound,
    input  logic                                i_edge_present,
    input  logic signed [ubbb_pkg::VAL_W-1:0]   i_reward,
    input  logic signed [ubbb_pkg::VAL_W-1:0]   i_old_bound,
    input  logic                                i_last_outcome,
    input  logic                                i_last_action,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [ubbb_pkg::VAL_W-1:0]   o_q_value,
    output logic [ubbb_pkg::IDX_W-1:0]          o_action_index,
    output logic                                o_node_done,
    output logic signed [ubbb_pkg::VAL_W-1:0]   o_new_bound,
    output logic [ubbb_pkg::IDX_W-1:0]          o_best_action
);

    localparam int CW = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
    localparam int SW = ubbb_pkg::SUM_W;
    localparam int PW = ubbb_pkg::PROD_W;
    localparam int VW = ubbb_pkg::VAL_W;
    localparam int DW = ubbb_pkg::DPROD_W;

    logic [ubbb_pkg::DISC_W-1:0]   r_discount;
    logic signed [PW-1:0]          r_prod;
    logic                          r_edge;
    logic                          r_last_out;
    logic                          r_last_act;
    logic signed [VW-1:0]          r_reward;
    logic signed [VW-1:0]          r_old_bound;
    logic signed [SW-1:0]          r_sum;
    logic signed [DW-1:0]          r_dprod;
    logic signed [VW-1:0]          r_q;
    logic [CW-1:0]                 r_count;
    logic signed [VW-1:0]          r_best_val;
    logic [CW-1:0]                 r_best_idx;
    logic                          r_out_valid;
    logic signed [VW-1:0]          r_out_q;
    logic [ubbb_pkg::IDX_W-1:0]    r_out_idx;
    logic                          r_out_done;
    logic signed [VW-1:0]          r_out_bound;
    logic [ubbb_pkg::IDX_W-1:0]    r_out_best;

    logic signed [PW:0]            sum_full;
    logic signed [SW-1:0]          sum_sat;
    logic signed [SW:0]            sum_rnd;
    logic signed [ubbb_pkg::RSUM_W-1:0] sum_q16;
    logic signed [DW:0]            dprod_rnd;
    logic signed [DW-16:0]         dprod_q16;
    logic signed [DW-15:0]         q_full;
    logic signed [VW-1:0]          q_sat;
    logic                          q_gt;
    logic signed [VW-1:0]          best_val;
    logic [CW-1:0]                 best_idx;
    logic signed [VW-1:0]          new_bound;
    logic [CW+ubbb_pkg::IDX_W-1:0] count_ext;
    logic [CW+ubbb_pkg::IDX_W-1:0] best_ext;
    logic [CW-1:0]                 count_inc;

    always_comb begin
        sum_full = (PW+1)'(r_sum) + (PW+1)'(r_prod);
        if (sum_full[PW:SW-1] == '0 || sum_full[PW:SW-1] == '1) begin
            sum_sat = sum_full[SW-1:0];
        end else if (sum_full[PW]) begin
            sum_sat = {1'b1, {(SW-1){1'b0}}};
        end else begin
            sum_sat = {1'b0, {(SW-1){1'b1}}};
        end

        sum_rnd   = (SW+1)'(r_sum) + (SW+1)'(32768);
        sum_q16   = sum_rnd[SW:16];

        dprod_rnd = (DW+1)'(r_dprod) + (DW+1)'(32768);
        dprod_q16 = dprod_rnd[DW:16];
        q_full    = (DW-14)'(dprod_q16) + (DW-14)'(r_reward);
        if (q_full[DW-15:VW-1] == '0 || q_full[DW-15:VW-1] == '1) begin
            q_sat = q_full[VW-1:0];
        end else if (q_full[DW-15]) begin
            q_sat = {1'b1, {(VW-1){1'b0}}};
        end else begin
            q_sat = {1'b0, {(VW-1){1'b1}}};
        end

        q_gt      = r_q > r_best_val;
        best_val  = q_gt ? r_q : r_best_val;
        best_idx  = q_gt ? r_count : r_best_idx;
        new_bound = (r_old_bound < best_val) ? r_old_bound : best_val;
        count_ext = {{ubbb_pkg::IDX_W{1'b0}}, r_count};
        best_ext  = {{ubbb_pkg::IDX_W{1'b0}}, best_idx};
        count_inc = (r_count == CW'(MAX_ACTIONS - 1)) ? '0 : r_count + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_prod      <= $signed({1'b0, i_prob}) * i_next_bound;
            r_edge      <= i_edge_present;
            r_last_out  <= i_last_outcome;
            r_last_act  <= i_last_action;
            r_reward    <= i_reward;
            r_old_bound <= i_old_bound;
        end
        if (i_cmd.round_mul) begin
            r_dprod <= sum_q16 * $signed({1'b0, r_discount});
        end
        if (i_cmd.finish) begin
            r_q <= q_sat;
        end
        if (i_cmd.emit) begin
            r_out_q     <= r_q;
            r_out_idx   <= count_ext[ubbb_pkg::IDX_W-1:0];
            r_out_done  <= r_last_act;
            r_out_bound <= r_last_act ? new_bound : '0;
            r_out_best  <= r_last_act ? best_ext[ubbb_pkg::IDX_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discount  <= ubbb_pkg::DISCOUNT_RST;
            r_sum       <= '0;
            r_count     <= '0;
            r_best_val  <= {1'b1, {(VW-1){1'b0}}};
            r_best_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_discount <= i_cfg_data;
            end
            if (i_cmd.accumulate && r_edge) begin
                r_sum <= sum_sat;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_sum       <= '0;
                if (r_last_act) begin
                    r_count    <= '0;
                    r_best_val <= {1'b1, {(VW-1){1'b0}}};
                    r_best_idx <= '0;
                end else begin
                    r_count    <= count_inc;
                    r_best_val <= best_val;
                    r_best_idx <= best_idx;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.last_out  = r_last_out;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_q_value       = r_out_q;
    assign o_action_index  = r_out_idx;
    assign o_node_done     = r_out_done;
    assign o_new_bound     = r_out_bound;
    assign o_best_action   = r_out_best;

endmodule

>>> rtl/upper_bound_bellman_backup_core.sv
// ----------------------------------------------------------------------------
// upper_bound_bellman_backup_core
// Streaming upper-bound Bellman backup of one node, one outcome edge per beat.
// ----------------------------------------------------------------------------
// An input beat that is not the last outcome of its action has its
// probability-times-bound product registered on acceptance and added
// into the saturating 48-bit sum in the next cycle. For a beat with tlast
// set, after the sum the core rounds, multiplies by the discount, adds the
// reward with saturation, then waits for a free output register to update
// the running maximum and load the result. One result beat leaves per
// action; tlast on the result closes the node, carries the new bound and
// best action, and clears the node state.
// The discount register may be written at any cycle the block is idle.
module upper_bound_bellman_backup_core #(
    parameter int MAX_ACTIONS = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [16:0]   i_cfg_data,      // discount
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [119:0]  i_s_axis_tdata,  // prob, next_bound, reward, old_bound
    input  logic [1:0]    i_s_axis_tuser,  // edge_present, last_action
    input  logic          i_s_axis_tlast,  // last_outcome
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [79:0]   o_m_axis_tdata,  // q_value, action_index, new_bound,
                                           // best_action
    output logic          o_m_axis_tlast   // node_done
);

    ubbb_pkg::t_dp_cmd cmd;
    ubbb_pkg::t_dp_sts sts;

    logic signed [31:0] q_value;
    logic [7:0]         action_index;
    logic signed [31:0] new_bound;
    logic [7:0]         best_action;

    assign o_cfg_ready = i_rst_n;

    ubbb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ubbb_datapath #(
        .MAX_ACTIONS (MAX_ACTIONS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_prob         (i_s_axis_tdata[16:0]),
        .i_next_bound   ($signed(i_s_axis_tdata[48:17])),
        .i_edge_present (i_s_axis_tuser[0]),
        .i_reward       ($signed(i_s_axis_tdata[80:49])),
        .i_old_bound    ($signed(i_s_axis_tdata[112:81])),
        .i_last_outcome (i_s_axis_tlast),
        .i_last_action  (i_s_axis_tuser[1]),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_q_value      (q_value),
        .o_action_index (action_index),
        .o_node_done    (o_m_axis_tlast),
        .o_new_bound    (new_bound),
        .o_best_action  (best_action)
    );

    assign o_m_axis_tdata = {best_action, new_bound, action_index, q_value};

endmodule
